// ===== rtl/mck_pkg.sv =====
// ----------------------------------------------------------------------------
// mck_pkg
// Types, constants and the character table shared by the Morse keyer modules.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int CHAR_W   = 8;
  localparam int DOT_W    = 10;
  localparam int DUR_W    = 13;
  localparam int MAX_ELEM = 6;
  localparam int LEN_W    = 3;
  localparam int Q_DEPTH  = 2;

  localparam logic [DOT_W-1:0] DOT_MS_RESET = 10'd85;

  // Register index decoded from paddr[2].
  localparam logic REG_DOT_MS = 1'b0;

  localparam logic [CHAR_W-1:0] SPACE_CODE  = 8'd32;
  localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'd97;
  localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'd122;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

  // Segment lengths in units.
  localparam logic [1:0] UNITS_1 = 2'd0;
  localparam logic [1:0] UNITS_2 = 2'd1;
  localparam logic [1:0] UNITS_3 = 2'd2;
  localparam logic [1:0] UNITS_6 = 2'd3;

  // A classified character. The pattern is left-aligned: element 0 sits in
  // the top bit, and a one marks a dash.
  typedef struct packed {
    logic                is_space;
    logic [LEN_W-1:0]    len;
    logic [MAX_ELEM-1:0] pat;
  } mck_word_t;

  typedef struct packed {
    logic      known;
    mck_word_t word;
  } mck_class_t;

  function automatic mck_class_t mck_classify(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0]   c;
    logic [LEN_W-1:0]    n;
    logic [MAX_ELEM-1:0] p;
    logic                ok;
    mck_class_t          r;
    c  = ch;
    n  = 3'd0;
    p  = 6'b000000;
    ok = 1'b1;
    if (c >= LOWER_FIRST && c <= LOWER_LAST) begin
      c = c - CASE_OFFSET;
    end
    case (c)
      "A": begin n = 3'd2; p = 6'b010000; end
      "B": begin n = 3'd4; p = 6'b100000; end
      "C": begin n = 3'd4; p = 6'b101000; end
      "D": begin n = 3'd3; p = 6'b100000; end
      "E": begin n = 3'd1; p = 6'b000000; end
      "F": begin n = 3'd4; p = 6'b001000; end
      "G": begin n = 3'd3; p = 6'b110000; end
      "H": begin n = 3'd4; p = 6'b000000; end
      "I": begin n = 3'd2; p = 6'b000000; end
      "J": begin n = 3'd4; p = 6'b011100; end
      "K": begin n = 3'd3; p = 6'b101000; end
      "L": begin n = 3'd4; p = 6'b010000; end
      "M": begin n = 3'd2; p = 6'b110000; end
      "N": begin n = 3'd2; p = 6'b100000; end
      "O": begin n = 3'd3; p = 6'b111000; end
      "P": begin n = 3'd4; p = 6'b011000; end
      "Q": begin n = 3'd4; p = 6'b110100; end
      "R": begin n = 3'd3; p = 6'b010000; end
      "S": begin n = 3'd3; p = 6'b000000; end
      "T": begin n = 3'd1; p = 6'b100000; end
      "U": begin n = 3'd3; p = 6'b001000; end
      "V": begin n = 3'd4; p = 6'b000100; end
      "W": begin n = 3'd3; p = 6'b011000; end
      "X": begin n = 3'd4; p = 6'b100100; end
      "Y": begin n = 3'd4; p = 6'b101100; end
      "Z": begin n = 3'd4; p = 6'b110000; end
      "1": begin n = 3'd5; p = 6'b011110; end
      "2": begin n = 3'd5; p = 6'b001110; end
      "3": begin n = 3'd5; p = 6'b000110; end
      "4": begin n = 3'd5; p = 6'b000010; end
      "5": begin n = 3'd5; p = 6'b000000; end
      "6": begin n = 3'd5; p = 6'b100000; end
      "7": begin n = 3'd5; p = 6'b110000; end
      "8": begin n = 3'd5; p = 6'b111000; end
      "9": begin n = 3'd5; p = 6'b111100; end
      "0": begin n = 3'd5; p = 6'b111110; end
      "?": begin n = 3'd6; p = 6'b001100; end
      "=": begin n = 3'd5; p = 6'b100010; end
      ",": begin n = 3'd6; p = 6'b110011; end
      "/": begin n = 3'd5; p = 6'b100100; end
      default: ok = 1'b0;
    endcase
    r.word.is_space = (ch == SPACE_CODE);
    r.word.len      = n;
    r.word.pat      = p;
    r.known         = ok || (ch == SPACE_CODE);
    return r;
  endfunction

endpackage

// ===== rtl/mck_front.sv =====
// ----------------------------------------------------------------------------
// mck_front
// Accepts characters, classifies them and pushes known ones into the queue.
// ----------------------------------------------------------------------------
module mck_front (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mck_pkg::CHAR_W-1:0] character,
  input  logic                       q_full,
  output logic                       q_push,
  output mck_pkg::mck_word_t         q_word
);
  import mck_pkg::*;

  mck_class_t cls;

  assign cls      = mck_classify(character);
  assign in_ready = !q_full;
  // Characters with no Morse meaning are taken and dropped here.
  assign q_push   = in_valid && !q_full && cls.known;
  assign q_word   = cls.word;

endmodule

// ===== rtl/mck_queue.sv =====
// ----------------------------------------------------------------------------
// mck_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module mck_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mck_pkg::mck_word_t push_word,
  input  logic               pop,
  output mck_pkg::mck_word_t head,
  output logic               full,
  output logic               empty
);
  import mck_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  mck_word_t        entry [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/mck_back.sv =====
// ----------------------------------------------------------------------------
// mck_back
// Segment sequencer: turns one queued word into its run of key segments.
// ----------------------------------------------------------------------------
module mck_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [mck_pkg::DOT_W-1:0] dot_ms,
  input  mck_pkg::mck_word_t        head,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      key_on,
  output logic [mck_pkg::DUR_W-1:0] duration_ms,
  output logic                      last
);
  import mck_pkg::*;

  localparam logic [1:0] PH_SPACE = 2'd0;
  localparam logic [1:0] PH_ON    = 2'd1;
  localparam logic [1:0] PH_GAP   = 2'd2;
  localparam logic [1:0] PH_END   = 2'd3;

  logic                busy;
  logic [1:0]          phase;
  logic [LEN_W-1:0]    rem;
  logic [MAX_ELEM-1:0] pat;

  logic       emit;
  logic       seg_on;
  logic       seg_last;
  logic [1:0] seg_units;
  logic [DUR_W-1:0] dot_ext;
  logic [DUR_W-1:0] dot_x3;
  logic [DUR_W-1:0] seg_dur;

  assign q_pop = !busy && !q_empty;
  assign emit  = busy && (!out_valid || out_ready);

  always_comb begin
    seg_on    = 1'b0;
    seg_last  = 1'b0;
    seg_units = UNITS_1;
    unique case (phase)
      PH_SPACE: begin
        seg_units = UNITS_6;
        seg_last  = 1'b1;
      end
      PH_ON: begin
        seg_on    = 1'b1;
        seg_units = pat[MAX_ELEM-1] ? UNITS_3 : UNITS_1;
      end
      PH_GAP: begin
        seg_units = UNITS_1;
      end
      PH_END: begin
        seg_units = UNITS_2;
        seg_last  = 1'b1;
      end
      default: seg_units = UNITS_1;
    endcase
  end

  // Unit multiples are built from shifts and one add.
  assign dot_ext = DUR_W'(dot_ms);
  assign dot_x3  = dot_ext + (dot_ext << 1);

  always_comb begin
    case (seg_units)
      UNITS_1: seg_dur = dot_ext;
      UNITS_2: seg_dur = dot_ext << 1;
      UNITS_3: seg_dur = dot_x3;
      default: seg_dur = dot_x3 << 1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_SPACE;
      rem   <= '0;
      pat   <= '0;
    end else if (q_pop) begin
      busy  <= 1'b1;
      phase <= head.is_space ? PH_SPACE : PH_ON;
      rem   <= head.len;
      pat   <= head.pat;
    end else if (emit) begin
      unique case (phase)
        PH_SPACE: busy <= 1'b0;
        PH_ON: begin
          phase <= PH_GAP;
          pat   <= pat << 1;
        end
        PH_GAP: begin
          rem   <= rem - 1'b1;
          phase <= (rem == LEN_W'(1)) ? PH_END : PH_ON;
        end
        PH_END: busy <= 1'b0;
        default: busy <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      key_on      <= seg_on;
      duration_ms <= seg_dur;
      last        <= seg_last;
    end
  end

  a_last_ends_word: assert property (@(posedge clk) disable iff (rst)
    (emit && seg_last) |=> !busy)
    else $error("sequencer still busy after the final segment");

  a_elements_left: assert property (@(posedge clk) disable iff (rst)
    (busy && (phase == PH_ON || phase == PH_GAP)) |-> rem != '0)
    else $error("element segment with no elements left");

  a_no_pop_when_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !q_pop)
    else $error("word taken while the previous one is in progress");

endmodule

// ===== rtl/morse_code_keyer_core.sv =====
// Path: an accepted character goes into the queue, then into the idle sequencer, and its
// segments are registered at the output. The sequencer emits one segment per cycle while
// the output is not stalled; a code of n elements gives 2n+1 segments, a space one.
// A two-word queue lets the input side keep taking characters while segments drain.
// Reset: synchronous; dot_ms returns to 85, the queue empties and no segment is valid.
// ----------------------------------------------------------------------------
// morse_code_keyer_core
// Morse keyer: ASCII characters in, timed key segments out, APB unit register.
// ----------------------------------------------------------------------------
module morse_code_keyer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mck_pkg::CHAR_W-1:0] character,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       key_on,
  output logic [mck_pkg::DUR_W-1:0]  duration_ms,
  output logic                       last
);
  import mck_pkg::*;

  logic [DOT_W-1:0] dot_ms;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  mck_word_t        q_in;
  mck_word_t        q_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DOT_MS) ? 32'(dot_ms) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ms <= DOT_MS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DOT_MS) begin
      dot_ms <= pwdata[DOT_W-1:0];
    end
  end

  mck_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_word    (q_in)
  );

  mck_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  mck_back u_back (
    .clk         (clk),
    .rst         (rst),
    .dot_ms      (dot_ms),
    .head        (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_on      (key_on),
    .duration_ms (duration_ms),
    .last        (last)
  );

endmodule

// ===== verif/tb_morse_code_keyer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_morse_code_keyer_core
// Streams characters into the keyer and checks every key segment against a
// local Morse table: key state, length in ms and the end-of-character mark.
// The unit length is reprogrammed between phases, including the extremes.
// ----------------------------------------------------------------------------
module tb_morse_code_keyer_core;
  import mck_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_MAX    = 10;

  localparam int DOT_UNITS  = 1;
  localparam int DASH_UNITS = 3;
  localparam int GAP_UNITS  = 1;
  localparam int TAIL_UNITS = 2;
  localparam int WORD_UNITS = 6;

  localparam logic [2:0] ADDR_DOT_MS = {REG_DOT_MS, 2'b00};
  localparam logic [2:0] ADDR_SPARE  = {~REG_DOT_MS, 2'b00};

  typedef struct packed {
    logic             key;
    logic [DUR_W-1:0] dur;
    logic             fin;
  } segment_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = 3'd0;
  logic [31:0]       pwdata = 32'd0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAR_W-1:0] character = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              key_on;
  logic [DUR_W-1:0]  duration_ms;
  logic              last;

  logic [DOT_W-1:0]  unit_ms = DOT_MS_RESET;
  logic [CHAR_W-1:0] chars_to_send[$];
  segment_t          segs_due[$];
  int                fault_count = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 25;
  int                recv_idle_pct = 69;
  int                hold_left = 0;
  logic              hold_kick = 1'b0;

  morse_code_keyer_core DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .character   (character),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_on      (key_on),
    .duration_ms (duration_ms),
    .last        (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Dots and dashes for a character after case folding; empty if it has none.
  function automatic string morse_of(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] c;
    c = ch;
    if (c >= LOWER_FIRST && c <= LOWER_LAST) begin
      c = c - CASE_OFFSET;
    end
    case (c)
      "A": return ".-";     "B": return "-...";   "C": return "-.-.";
      "D": return "-..";    "E": return ".";      "F": return "..-.";
      "G": return "--.";    "H": return "....";   "I": return "..";
      "J": return ".---";   "K": return "-.-";    "L": return ".-..";
      "M": return "--";     "N": return "-.";     "O": return "---";
      "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
      "S": return "...";    "T": return "-";      "U": return "..-";
      "V": return "...-";   "W": return ".--";    "X": return "-..-";
      "Y": return "-.--";   "Z": return "--..";
      "1": return ".----";  "2": return "..---";  "3": return "...--";
      "4": return "....-";  "5": return ".....";  "6": return "-....";
      "7": return "--...";  "8": return "---..";  "9": return "----.";
      "0": return "-----";
      "?": return "..--.."; "=": return "-...-";  ",": return "--..--";
      "/": return "-..-.";
      default: return "";
    endcase
  endfunction

  function automatic void add_segment(input logic key, input int units, input logic fin);
    segment_t s;
    s.key = key;
    s.dur = DUR_W'(units * unit_ms);
    s.fin = fin;
    segs_due.push_back(s);
  endfunction

  function automatic void predict_segments(input logic [CHAR_W-1:0] ch);
    string code;
    code = morse_of(ch);
    if (ch == SPACE_CODE) begin
      add_segment(1'b0, WORD_UNITS, 1'b1);
    end else if (code.len() > 0) begin
      for (int i = 0; i < code.len(); i++) begin
        add_segment(1'b1, (code[i] == "-") ? DASH_UNITS : DOT_UNITS, 1'b0);
        add_segment(1'b0, GAP_UNITS, 1'b0);
      end
      add_segment(1'b0, TAIL_UNITS, 1'b1);
    end
  endfunction

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_MAX) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  // Mostly characters that key something, with arbitrary codes mixed in.
  function automatic logic [CHAR_W-1:0] pick_char();
    string alphabet;
    alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789?=,/ ";
    if ($urandom_range(99) < 80) begin
      return alphabet[$urandom_range(alphabet.len() - 1)];
    end
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic queue_random(input int n);
    int keyed;
    logic [CHAR_W-1:0] c;
    string code;
    keyed = 0;
    while (keyed < n) begin
      c = pick_char();
      chars_to_send.push_back(c);
      code = morse_of(c);
      if (c == SPACE_CODE || code.len() > 0) begin
        keyed++;
      end
    end
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == REG_DOT_MS) begin
      unit_ms = data[DOT_W-1:0];
    end
  endtask

  task automatic apb_read_check(input logic [2:0] addr);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== 32'(unit_ms)) begin
      note_fault($sformatf("dot_ms read: expected %0d, got %0d", unit_ms, prdata));
    end
  endtask

  // Unknown characters leave no trace in the result stream, so allow the
  // block a settling period once the last segment has gone.
  task automatic wait_drained();
    while (chars_to_send.size() != 0 || in_valid || segs_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [DOT_W-1:0] dot, input int n, input int s_idle,
                           input int r_idle, input bit hold);
    wait_drained();
    apb_write(ADDR_DOT_MS, {22'($urandom), dot});
    apb_read_check(ADDR_DOT_MS);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    if (hold) begin
      hold_kick <= 1'b1;
      @(posedge clk);
      hold_kick <= 1'b0;
    end
    queue_random(n);
  endtask

  // Driver: a word stays on the port until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_segments(character);
      end
      if (!in_valid || in_ready) begin
        if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          character <= chars_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : monitor_p
    segment_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (segs_due.size() == 0) begin
          note_fault($sformatf("unexpected segment key=%0b dur=%0d last=%0b",
                               key_on, duration_ms, last));
        end else begin
          due = segs_due.pop_front();
          if (key_on !== due.key || duration_ms !== due.dur || last !== due.fin) begin
            note_fault($sformatf(
              "segment mismatch: expected key=%0b dur=%0d last=%0b, got key=%0b dur=%0d last=%0b",
              due.key, due.dur, due.fin, key_on, duration_ms, last));
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset unit length: folding boundaries, every
    // kind of code, the space and characters with no Morse meaning.
    apb_read_check(ADDR_DOT_MS);
    chars_to_send = '{"A", "Z", "a", "z", "e", "t", "0", "9", "5", "?", "=", ",", "/",
                      " ", 8'h00, 8'hFF, 8'h80, 8'h60, 8'h7B, 8'h40, 8'h5B, 8'h2E};

    // A write to the unused address must leave the unit length alone.
    run_phase(10'd1, 70, 25, 69, 1'b1);
    wait_drained();
    apb_write(ADDR_SPARE, 32'd777);
    apb_read_check(ADDR_DOT_MS);
    chars_to_send.push_back("E");
    chars_to_send.push_back(" ");

    run_phase(10'd1000, 70, 69, 25, 1'b0);
    run_phase(10'd0, 45, 69, 25, 1'b0);
    run_phase(10'd1023, 55, 0, 0, 1'b1);
    run_phase(10'($urandom_range(999, 2)), 60, 0, 0, 1'b0);
    run_phase(10'd1001, 35, 0, 0, 1'b0);

    wait_drained();
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
